### rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude unit.
package sem_pkg;

   localparam int CFG_IDX_WIDTH = 1;
   localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAME_WIDTH = 1'b0;
   localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAME_HEIGHT = 1'b1;
   localparam logic [10:0] WIDTH_RESET = 11'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;
   localparam logic [7:0] MAG_MAX = 8'd255;

   typedef logic [23:0] pix_type;

   // One window job handed from the front to the back part
   typedef struct packed {
      pix_type [2:0] left;    // rows 0..2, column 0
      pix_type [2:0] center;  // column 1
      pix_type [2:0] right;   // column 2
      logic last_run;
      logic last_frame;
   } job_type;

   // Per-channel Sobel sum of squares (max 2*1020^2 < 2^21)
   function automatic logic [20:0] sobel_sq(input job_type j, input int k);
      logic signed [11:0] a, b, c, d, f, h, i, q, gx, gy;
      logic [20:0] s;
      a = {4'd0, j.left[0][8*k +: 8]};
      b = {4'd0, j.center[0][8*k +: 8]};
      c = {4'd0, j.right[0][8*k +: 8]};
      d = {4'd0, j.left[1][8*k +: 8]};
      f = {4'd0, j.right[1][8*k +: 8]};
      h = {4'd0, j.left[2][8*k +: 8]};
      i = {4'd0, j.center[2][8*k +: 8]};
      q = {4'd0, j.right[2][8*k +: 8]};
      gx = (c - a) + ((f - d) <<< 1) + (q - h);
      gy = (h + (i <<< 1) + q) - (a + (b <<< 1) + c);
      s = 21'(gx * gx) + 21'(gy * gy);
      return s;
   endfunction

endpackage

### rtl/sobel_edge_magnitude_rgb_unit.sv
// Sobel edge magnitude unit: front part, job queue, back part.
// The front part takes a new pixel only after the last one's jobs are handed on;
// the back part runs an 11-step square root per result and takes no new job
// until that result is loaded, so the root unit sets the rate.
// Reset (synchronous): positions and job flags clear, width 640, height 480;
// line stores hold no reset value and are masked by row position.
module sobel_edge_magnitude_rgb_unit
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   input  logic req_tuser,          // kind
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,   // red_edge, green_edge, blue_edge
   output logic rsp_tlast,          // last_of_run
   output logic rsp_tuser,          // last_of_frame
   input  logic csr_we,
   input  logic [CFG_IDX_WIDTH-1:0] csr_index,
   input  logic [12:0] csr_wdata
);
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fjob, bjob;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH: width_ff <= csr_wdata[10:0];
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_kind(req_tuser), .in_pix(req_tdata),
      .cfg_width(width_ff), .cfg_height(height_ff),
      .job_valid(fj_valid), .job(fjob), .job_ready(fj_ready)
   );

   sem_queue u_queue (
      .clock, .reset,
      .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fjob),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bjob)
   );

   sem_back u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_red(rsp_tdata[7:0]), .out_green(rsp_tdata[15:8]),
      .out_blue(rsp_tdata[23:16]),
      .out_last_run(rsp_tlast), .out_last_frame(rsp_tuser)
   );

`ifndef SYNTHESIS
   // A frame-end result always closes its run
   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser || rsp_tlast)) else $error("frame end without last");
   // A waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
`endif
endmodule

### rtl/sem_front.sv
// Front part: position tracking, line stores, window and job forming.
module sem_front
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic in_kind,
   input  pix_type in_pix,
   input  logic [10:0] cfg_width,
   input  logic [12:0] cfg_height,
   output logic job_valid,
   output job_type job,
   input  logic job_ready
);
   localparam int AW = $clog2(MAX_WIDTH);

   typedef enum logic [1:0] {ST_READ, ST_EMIT, ST_EMIT2} state_type;

   pix_type upper_mem [MAX_WIDTH];
   pix_type middle_mem [MAX_WIDTH];
   pix_type top_rd_ff, mid_rd_ff;

   state_type state_ff;
   logic [AW-1:0] col_ff;
   logic [12:0] row_ff;
   pix_type px_ff;
   logic [AW-1:0] pcol_ff;
   logic [12:0] prow_ff;
   pix_type [2:0] wc_ff, wr_ff;

   logic [AW:0] w_eff;
   logic [12:0] h_eff;
   logic pos_bad;
   logic [AW-1:0] col_use;
   logic [12:0] row_use;
   logic accept;
   logic job_load;
   pix_type px_in;
   logic is_last_col;
   logic has_first;
   pix_type top_v, mid_v;

   always_comb begin
      if (cfg_width == 11'd0) w_eff = (AW+1)'(1);
      else if (int'(cfg_width) > MAX_WIDTH) w_eff = (AW+1)'(MAX_WIDTH);
      else w_eff = (AW+1)'(cfg_width);
      h_eff = (cfg_height == 13'd0) ? 13'd1 : cfg_height;
      pos_bad = ({1'b0, col_ff} >= w_eff) || (row_ff > h_eff);
      col_use = pos_bad ? '0 : col_ff;
      row_use = pos_bad ? '0 : row_ff;
   end

   assign in_ready = (state_ff == ST_READ);
   assign accept = in_valid && in_ready;
   assign px_in = (!in_kind && row_use < h_eff) ? in_pix : '0;
   assign job_load = (state_ff != ST_READ) && (!job_valid || job_ready);

   // Line stores: read old entries, then move the old middle entry up
   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff <= upper_mem[col_use];
         mid_rd_ff <= middle_mem[col_use];
         middle_mem[col_use] <= px_in;
      end
      if (state_ff == ST_EMIT) upper_mem[pcol_ff] <= mid_rd_ff;
   end

   assign top_v = (prow_ff >= 13'd2) ? top_rd_ff : '0;
   assign mid_v = (prow_ff >= 13'd1) ? mid_rd_ff : '0;
   assign is_last_col = ({1'b0, pcol_ff} == w_eff - (AW+1)'(1));
   assign has_first = (prow_ff >= 13'd1) && (pcol_ff != '0);

   // Sequencer: read cycle, then window shift and up to two jobs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READ;
         col_ff <= '0;
         row_ff <= '0;
         job_valid <= 1'b0;
      end else begin
         if (job_valid && job_ready && !job_load) job_valid <= 1'b0;
         unique case (state_ff)
            ST_READ: begin
               if (accept) begin
                  px_ff <= px_in;
                  pcol_ff <= col_use;
                  prow_ff <= row_use;
                  if ({1'b0, col_use} + (AW+1)'(1) >= w_eff) begin
                     col_ff <= '0;
                     row_ff <= (row_use + 13'd1 > h_eff) ? 13'd0 : row_use + 13'd1;
                  end else begin
                     col_ff <= col_use + AW'(1);
                     row_ff <= row_use;
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (job_load) begin
                  wc_ff <= (pcol_ff == '0) ? '0 : wr_ff;
                  wr_ff <= {px_ff, mid_v, top_v};
                  job.left <= wc_ff;
                  job.center <= wr_ff;
                  job.right <= {px_ff, mid_v, top_v};
                  job.last_run <= !(is_last_col && prow_ff >= 13'd1);
                  job.last_frame <= 1'b0;
                  job_valid <= has_first;
                  if (prow_ff >= 13'd1 && is_last_col) state_ff <= ST_EMIT2;
                  else state_ff <= ST_READ;
               end
            end
            ST_EMIT2: begin
               if (job_load) begin
                  job.left <= wc_ff;
                  job.center <= wr_ff;
                  job.right <= '0;
                  job.last_run <= 1'b1;
                  job.last_frame <= (prow_ff == h_eff);
                  job_valid <= 1'b1;
                  state_ff <= ST_READ;
               end
            end
            default: state_ff <= ST_READ;
         endcase
      end
   end
endmodule

### rtl/sem_queue.sv
// Two-entry queue between front and back parts.
module sem_queue
   import sem_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   output logic wr_ready,
   input  job_type wr_data,
   output logic rd_valid,
   input  logic rd_ready,
   output job_type rd_data
);
   job_type slot_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data = slot_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

### rtl/sem_back.sv
// Back part: Sobel sums, iterative rounded square root, result register.
module sem_back
   import sem_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  job_type job,
   output logic out_valid,
   input  logic out_ready,
   output logic [7:0] out_red,
   output logic [7:0] out_green,
   output logic [7:0] out_blue,
   output logic out_last_run,
   output logic out_last_frame
);
   typedef enum logic [1:0] {ST_IDLE, ST_SQ, ST_ROOT} state_type;

   state_type state_ff;
   logic [20:0] rem_ff [3];
   logic [20:0] root_ff [3];
   logic [3:0] step_ff;
   logic lr_ff, lf_ff;
   job_type job_ff;

   logic [20:0] rem_in [3];
   logic [20:0] root_in [3];
   logic [7:0] mag [3];
   logic [21:0] bitv;
   logic out_load;

   // One root digit per cycle, all three channels together
   always_comb begin
      bitv = 22'(1) << (2 * (4'd10 - step_ff));
      for (int k = 0; k < 3; k++) begin
         logic [21:0] trial;
         logic [11:0] fin;
         trial = {1'b0, root_ff[k]} + bitv;
         if ({1'b0, rem_ff[k]} >= trial) begin
            rem_in[k] = rem_ff[k] - trial[20:0];
            root_in[k] = 21'(({1'b0, root_ff[k]} >> 1) + bitv);
         end else begin
            rem_in[k] = rem_ff[k];
            root_in[k] = root_ff[k] >> 1;
         end
         fin = root_ff[k][11:0] + 12'(rem_ff[k] > root_ff[k]);
         mag[k] = (fin > 12'(MAG_MAX)) ? MAG_MAX : fin[7:0];
      end
   end

   assign job_ready = (state_ff == ST_IDLE);
   assign out_load = (state_ff == ST_ROOT) && (step_ff == 4'd11) && (!out_valid || out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid <= 1'b0;
         step_ff <= '0;
      end else begin
         if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff <= job;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               for (int k = 0; k < 3; k++) begin
                  rem_ff[k] <= sobel_sq(job_ff, k);
                  root_ff[k] <= '0;
               end
               lr_ff <= job_ff.last_run;
               lf_ff <= job_ff.last_frame;
               step_ff <= '0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (step_ff != 4'd11) begin
                  for (int k = 0; k < 3; k++) begin
                     rem_ff[k] <= rem_in[k];
                     root_ff[k] <= root_in[k];
                  end
                  step_ff <= step_ff + 4'd1;
               end else if (out_load) begin
                  out_red <= mag[0];
                  out_green <= mag[1];
                  out_blue <= mag[2];
                  out_last_run <= lr_ff;
                  out_last_frame <= lf_ff;
                  out_valid <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

### tb/tb_top.sv
// Self-checking testbench for the Sobel edge magnitude unit: random frames, predicted results.
module tb_top;
   import sem_pkg::*;

   // One predicted or observed result
   typedef struct {
      logic [23:0] edges;
      logic        run_end;
      logic        frame_end;
   } edge_result_type;

   // Tracks expected edge results from accepted pixels and checks arrivals
   class edge_scoreboard;
      pix_type        upper_line[1024];
      pix_type        middle_line[1024];
      pix_type        win[3][3];
      int unsigned    col_pos, row_pos;
      logic [10:0]    width_reg;
      logic [12:0]    height_reg;
      edge_result_type pending_q[$];
      int unsigned    fail_count;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         foreach (win[r, c]) win[r][c] = '0;
         col_pos = 0;
         row_pos = 0;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         fail_count = 0;
      endfunction

      function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [12:0] value);
         if (idx == REG_FRAME_WIDTH) width_reg = value[10:0];
         else height_reg = value;
      endfunction

      // Rounded integer root, saturated to 8 bits
      function logic [7:0] round_root(int unsigned s);
         int unsigned r, t;
         r = 0;
         for (int b = 11; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= s) r = t;
         end
         if (s - r * r > r) r++;
         return (r > 255) ? MAG_MAX : r[7:0];
      endfunction

      function logic [23:0] sobel_mag(pix_type g[3][3]);
         logic [23:0] res;
         int a, b, c, d, f, h, i, j, gx, gy;
         for (int k = 0; k < 3; k++) begin
            a = g[0][0][8*k +: 8]; b = g[0][1][8*k +: 8]; c = g[0][2][8*k +: 8];
            d = g[1][0][8*k +: 8]; f = g[1][2][8*k +: 8];
            h = g[2][0][8*k +: 8]; i = g[2][1][8*k +: 8]; j = g[2][2][8*k +: 8];
            gx = (c - a) + 2 * (f - d) + (j - h);
            gy = (h + 2 * i + j) - (a + 2 * b + c);
            res[8*k +: 8] = round_root(gx * gx + gy * gy);
         end
         return res;
      endfunction

      // Advance the predictor by one accepted pixel transfer
      function void note_pixel(logic kind, logic [23:0] data);
         int unsigned w, h, col, row;
         pix_type px, top, mid;
         pix_type g[3][3];
         edge_result_type res;
         int n;
         w = width_reg;
         h = height_reg;
         if (w < 1) w = 1;
         if (w > 1024) w = 1024;
         if (h < 1) h = 1;
         if (col_pos >= w || row_pos > h) begin
            col_pos = 0;
            row_pos = 0;
         end
         col = col_pos;
         row = row_pos;
         px = (kind == 1'b0 && row < h) ? data : '0;
         top = (row >= 2) ? upper_line[col] : '0;
         mid = (row >= 1) ? middle_line[col] : '0;
         upper_line[col] = middle_line[col];
         middle_line[col] = px;
         if (col == 0) foreach (win[r, c]) win[r][c] = '0;
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = px;
         n = 0;
         if (row >= 1) begin
            if (col >= 1) begin
               res.edges = sobel_mag(win);
               res.run_end = (col != w - 1);
               res.frame_end = 1'b0;
               pending_q.push_back(res);
               n++;
            end
            if (col == w - 1) begin
               for (int r = 0; r < 3; r++) begin
                  g[r][0] = win[r][1];
                  g[r][1] = win[r][2];
                  g[r][2] = '0;
               end
               res.edges = sobel_mag(g);
               res.run_end = 1'b1;
               res.frame_end = (row == h);
               pending_q.push_back(res);
            end
         end
         col++;
         if (col >= w) begin
            col = 0;
            row++;
            if (row > h) row = 0;
         end
         col_pos = col;
         row_pos = row;
      endfunction

      // Compare one accepted result transfer with the oldest expectation
      function void check_result(logic [23:0] edges, logic run_end, logic frame_end);
         edge_result_type exp_r;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result: got %h last %b frame %b",
                     $time, edges, run_end, frame_end);
            fail_count++;
            return;
         end
         exp_r = pending_q.pop_front();
         if (exp_r.edges !== edges) begin
            $display("%0t: edges mismatch: expected %h actual %h", $time, exp_r.edges, edges);
            fail_count++;
         end
         if (exp_r.run_end !== run_end) begin
            $display("%0t: tlast mismatch: expected %b actual %b",
                     $time, exp_r.run_end, run_end);
            fail_count++;
         end
         if (exp_r.frame_end !== frame_end) begin
            $display("%0t: tuser mismatch: expected %b actual %b",
                     $time, exp_r.frame_end, frame_end);
            fail_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;   // red_in, green_in, blue_in
   logic req_tuser = 1'b0;        // kind
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // red_edge, green_edge, blue_edge
   logic rsp_tlast;               // last_of_run
   logic rsp_tuser;               // last_of_frame
   logic csr_we = 1'b0;
   logic [CFG_IDX_WIDTH-1:0] csr_index = REG_FRAME_WIDTH;
   logic [12:0] csr_wdata = '0;

   edge_scoreboard sb = new();
   int unsigned pixels_sent = 0;
   int unsigned quiet_cycles = 0;
   bit no_gaps = 0;

   sobel_edge_magnitude_rgb_unit u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 6000) begin
         $display("** sobel_edge_magnitude_rgb_unit: FAILED **");
         $finish;
      end
   end

   // Result side: random stalls, with stall-free stretches
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   task automatic send_pixel(logic kind, logic [23:0] data);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(kind, data);
      pixels_sent++;
   endtask

   // Hold off until every expected result is back, then let the pipe settle
   task automatic drain_wait();
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [12:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   function automatic logic [23:0] rand_pixel();
      logic [23:0] p;
      p = 24'($urandom);
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 5))
            0: p[8*k +: 8] = 8'h00;
            1: p[8*k +: 8] = 8'hFF;
            default: ;
         endcase
      end
      return p;
   endfunction

   // One whole frame plus its drain row; odd_pct sets the share of misplaced kinds
   task automatic run_frame(logic [12:0] w_reg, logic [12:0] h_reg, int odd_pct);
      int w, h;
      drain_wait();
      write_reg(REG_FRAME_WIDTH, w_reg);
      write_reg(REG_FRAME_HEIGHT, h_reg);
      w = w_reg[10:0];
      h = h_reg;
      if (w < 1) w = 1;
      if (w > 1024) w = 1024;
      if (h < 1) h = 1;
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < (h + 1) * w; i++) begin
         if (i < h * w) send_pixel($urandom_range(0, 99) < odd_pct, rand_pixel());
         else send_pixel($urandom_range(0, 99) >= odd_pct, rand_pixel());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 3x2 frame with extremes and misplaced kinds
      write_reg(REG_FRAME_WIDTH, 13'd3);
      write_reg(REG_FRAME_HEIGHT, 13'd2);
      send_pixel(1'b0, 24'hFFFFFF);
      send_pixel(1'b0, 24'h000000);
      send_pixel(1'b0, 24'hFF00FF);
      send_pixel(1'b1, 24'hFFFFFF);   // drain kind inside the frame
      send_pixel(1'b0, 24'h00FF00);
      send_pixel(1'b0, 24'hFFFFFF);
      send_pixel(1'b1, 24'h123456);
      send_pixel(1'b0, 24'hFFFFFF);   // pixel kind in the drain row
      send_pixel(1'b1, 24'h000000);
      // Width zero and height zero act as one
      run_frame(13'd0, 13'd3, 0);
      run_frame(13'd4, 13'd0, 0);
      run_frame(13'd2, 13'd1, 20);

      // Random frames, mostly well formed
      while (pixels_sent < 1000)
         run_frame(13'($urandom_range(1, 12)), 13'($urandom_range(1, 6)),
                   ($urandom_range(0, 3) == 0) ? 15 : 0);

      // Larger sizes, and a width value with bits above the width field
      run_frame(13'h1003, 13'd2, 0);
      run_frame(13'd1, 13'd150, 0);
      run_frame(13'd90, 13'd1, 5);

      drain_wait();
      if (sb.fail_count == 0) $display("** sobel_edge_magnitude_rgb_unit: PASSED **");
      else $display("** sobel_edge_magnitude_rgb_unit: FAILED **");
      $finish;
   end

endmodule
